// ----- design/c_token_classifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// c_token_classifier_core_macros.svh
// Assertion helpers for the token classifier; clk and rst_n come from scope.
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_CLASSIFIER_CORE_MACROS_SVH
`define C_TOKEN_CLASSIFIER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token classifier check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token classifier check failed");

`endif

// ----- design/ctc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, result codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package ctc_pkg;

    localparam logic [2:0] KIND_KEYWORD    = 3'd0;
    localparam logic [2:0] KIND_INTEGER    = 3'd1;
    localparam logic [2:0] KIND_FLOAT      = 3'd2;
    localparam logic [2:0] KIND_OPERATOR   = 3'd3;
    localparam logic [2:0] KIND_IDENTIFIER = 3'd4;
    localparam logic [2:0] KIND_DELIMITER  = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Reported length saturates at the width of the token_length field.
    localparam int TOKEN_LEN_CAP = 4095;

    localparam int KW_COUNT = 22;

    // Keyword text is right-aligned: first character in the highest used byte.
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
        4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
    };

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("break"),
        64'("continue"), 64'("int"), 64'("double"), 64'("float"),
        64'("return"), 64'("char"), 64'("case"), 64'("sizeof"), 64'("long"),
        64'("short"), 64'("typedef"), 64'("switch"), 64'("unsigned"),
        64'("void"), 64'("static"), 64'("struct"), 64'("goto")
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  keyword_number;
        logic [11:0] token_length;
        logic [7:0]  lead_char;
        logic        last_of_run;
    } result_t;

    // Up to three results raised by one byte, packed from slot 0 upwards.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

endpackage

// ----- design/ctc_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_byte_if
// Request channel carrying one source character per request.
// ----------------------------------------------------------------------------
interface ctc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- design/ctc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_result_if
// Request channel carrying one token classification result per request.
// ----------------------------------------------------------------------------
interface ctc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  keyword_number;
    logic [11:0] token_length;
    logic [7:0]  lead_char;
    logic        last_of_run;

    modport source (output valid, output kind, output keyword_number,
                    output token_length, output lead_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input keyword_number,
                    input token_length, input lead_char, input last_of_run,
                    output ready);
endinterface

// ----- design/c_token_classifier_core.sv -----
`timescale 1ns / 1ps
// Latency: first result of a byte is offered the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte raises at most one result and
// the output is taken; a byte raising more holds the input until only its last
// result remains and is taken, since all results leave through the single result register.
// Reset: asynchronous, active low; token state and the result queue clear at
// once; the head character store needs no clearing pass.
// ----------------------------------------------------------------------------
// c_token_classifier_core
// Lexical token classifier: one source byte in, keyword / number / operator /
// identifier / delimiter reports out.
// ----------------------------------------------------------------------------
module c_token_classifier_core #(
    parameter int MAX_TOKEN_LEN = 4095,
    parameter int KEYWORD_SPAN  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    ctc_byte_if.sink            text_in,
    ctc_result_if.source        token_out
);
    import ctc_pkg::*;

`include "c_token_classifier_core_macros.svh"

    logic    in_accept;
    logic    take_ok;
    bundle_t bundle;
    result_t head_res;

    // Take a request whenever the result register is empty or drains this cycle.
    assign text_in.ready = take_ok;
    assign in_accept     = text_in.valid && take_ok;

    // Token state plus classifier: the byte and the stored token flags give
    // up to three results in one pass (closed token, delimiter, operator).
    ctc_tokeniser #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .KEYWORD_SPAN  (KEYWORD_SPAN)
    ) u_tokeniser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .text_byte (text_in.text_byte),
        .bundle    (bundle)
    );

    // Result register: hold the bundle and hand results out one per request.
    ctc_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .bundle    (bundle),
        .take_ok   (take_ok),
        .out_valid (token_out.valid),
        .out_ready (token_out.ready),
        .out_res   (head_res)
    );

    assign token_out.kind           = head_res.kind;
    assign token_out.keyword_number = head_res.keyword_number;
    assign token_out.token_length   = head_res.token_length;
    assign token_out.lead_char      = head_res.lead_char;
    assign token_out.last_of_run    = head_res.last_of_run;

    // A byte that raises results has its first one on offer next cycle.
    `CTC_ASSERT_NEXT(a_result_follows, in_accept && (bundle.count != 2'd0), token_out.valid)
    // While a byte still has results waiting behind the head, drop no new byte in.
    `CTC_ASSERT_SAME(a_hold_input, token_out.valid && !token_out.last_of_run, !text_in.ready)
    // Keywords span two to eight characters.
    `CTC_ASSERT_SAME(a_keyword_len, token_out.valid && (token_out.kind == KIND_KEYWORD),
                     (token_out.token_length >= 12'd2) && (token_out.token_length <= 12'd8))
    // Delimiter reports carry no length.
    `CTC_ASSERT_SAME(a_delim_len, token_out.valid && (token_out.kind == KIND_DELIMITER),
                     token_out.token_length == 12'd0)

endmodule

// ----- design/ctc_tokeniser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_tokeniser
// Token state registers and the single-step classifier that builds a bundle.
// ----------------------------------------------------------------------------
module ctc_tokeniser #(
    parameter int MAX_TOKEN_LEN = 4095,
    parameter int KEYWORD_SPAN  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    output ctc_pkg::bundle_t bundle
);
    import ctc_pkg::*;

    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int HEAD_W = $clog2(KEYWORD_SPAN);

    logic             token_open_reg, token_open_next;
    logic [LEN_W-1:0] kept_length_reg, kept_length_next;
    logic [7:0]       head_chars_reg [KEYWORD_SPAN];
    logic [7:0]       first_kept_reg, first_kept_next;
    logic             all_digits_reg, all_digits_next;
    logic             digits_or_dots_reg, digits_or_dots_next;
    logic             saw_dot_reg, saw_dot_next;
    logic             held_tab_reg, held_tab_next;

    logic             is_delim, is_special, is_angle, closes;
    logic             keep_tab, keep_byte, head_wr_a, head_wr_b;
    logic [LEN_W-1:0] len_after_tab;
    logic             kw_hit;
    logic [4:0]       kw_num;
    logic [LEN_W+11:0] len_wide;
    logic [11:0]      len_capped;
    logic [2:0]       tok_kind;
    logic             lead_is_op;
    logic [2:0]       cand_valid;
    result_t [2:0]    cand;

    // Delimiter classes
    always_comb
    begin
        is_delim = (text_byte == CH_HASH)   || (text_byte == CH_SPACE)  ||
                   (text_byte == CH_COMMA)  || (text_byte == CH_SEMI)   ||
                   (text_byte == CH_LT)     || (text_byte == CH_GT)     ||
                   (text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
                   (text_byte == CH_LBRACK) || (text_byte == CH_RBRACK) ||
                   (text_byte == CH_LBRACE) || (text_byte == CH_RBRACE);
        is_special = is_delim && (text_byte != CH_SPACE) &&
                     (text_byte != CH_COMMA) && (text_byte != CH_SEMI);
        is_angle = (text_byte == CH_LT) || (text_byte == CH_GT);
        closes   = is_delim || (text_byte == CH_NEWLINE);
    end

    // Keyword match against the stored head characters
    always_comb
    begin
        logic same;
        kw_hit = 1'b0;
        kw_num = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            same = (kept_length_reg == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < 8; i++)
            begin
                if (i < int'(KW_LEN[k]))
                begin
                    if (head_chars_reg[HEAD_W'(i)] !=
                        KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8])
                    begin
                        same = 1'b0;
                    end
                end
            end
            if (same && !kw_hit)
            begin
                kw_hit = 1'b1;
                kw_num = 5'(k);
            end
        end
    end

    // Classify the open token
    always_comb
    begin
        len_wide   = {12'd0, kept_length_reg};
        len_capped = (len_wide > (LEN_W+12)'(TOKEN_LEN_CAP)) ? 12'hFFF : len_wide[11:0];
        lead_is_op = (first_kept_reg == CH_PLUS)  || (first_kept_reg == CH_MINUS) ||
                     (first_kept_reg == CH_STAR)  || (first_kept_reg == CH_SLASH) ||
                     (first_kept_reg == CH_GT)    || (first_kept_reg == CH_LT)    ||
                     (first_kept_reg == CH_EQUAL) || (first_kept_reg == CH_PERCENT);
        priority if (kw_hit)
            tok_kind = KIND_KEYWORD;
        else if ((kept_length_reg != '0) && all_digits_reg)
            tok_kind = KIND_INTEGER;
        else if ((kept_length_reg != '0) && digits_or_dots_reg && saw_dot_reg)
            tok_kind = KIND_FLOAT;
        else if ((kept_length_reg != '0) && lead_is_op)
            tok_kind = KIND_OPERATOR;
        else
            tok_kind = KIND_IDENTIFIER;
    end

    // Gather candidates and pack them into the bundle
    always_comb
    begin
        logic [1:0] n;
        cand_valid[0] = closes && token_open_reg;
        cand_valid[1] = is_special;
        cand_valid[2] = is_angle;

        cand[0] = '{kind: tok_kind, keyword_number: kw_num, token_length: len_capped,
                    lead_char: first_kept_reg, last_of_run: 1'b0};
        cand[1] = '{kind: KIND_DELIMITER, keyword_number: 5'd0, token_length: 12'd0,
                    lead_char: text_byte, last_of_run: 1'b0};
        cand[2] = '{kind: KIND_OPERATOR, keyword_number: 5'd0, token_length: 12'd0,
                    lead_char: text_byte, last_of_run: 1'b0};

        n = 2'd0;
        bundle = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (cand_valid[j])
            begin
                bundle.res[n] = cand[j];
                n = n + 2'd1;
            end
        end
        if (n != 2'd0)
        begin
            bundle.res[n - 2'd1].last_of_run = 1'b1;
        end
        bundle.count = n;
    end

    // Next token state; a held tab is kept only ahead of '-'
    always_comb
    begin
        keep_tab  = held_tab_reg && (text_byte == CH_MINUS);
        keep_byte = (text_byte != CH_TAB);

        len_after_tab = kept_length_reg;
        if (keep_tab && (kept_length_reg != LEN_W'(MAX_TOKEN_LEN)))
            len_after_tab = kept_length_reg + LEN_W'(1);

        head_wr_a = keep_tab &&
                    ((LEN_W+1)'(kept_length_reg) < (LEN_W+1)'(KEYWORD_SPAN));
        head_wr_b = keep_byte &&
                    ((LEN_W+1)'(len_after_tab) < (LEN_W+1)'(KEYWORD_SPAN));

        token_open_next     = token_open_reg;
        kept_length_next    = kept_length_reg;
        first_kept_next     = first_kept_reg;
        all_digits_next     = all_digits_reg;
        digits_or_dots_next = digits_or_dots_reg;
        saw_dot_next        = saw_dot_reg;
        held_tab_next       = held_tab_reg;

        if (accept)
        begin
            if (closes)
            begin
                token_open_next     = 1'b0;
                kept_length_next    = '0;
                first_kept_next     = 8'd0;
                all_digits_next     = 1'b1;
                digits_or_dots_next = 1'b1;
                saw_dot_next        = 1'b0;
                held_tab_next       = 1'b0;
            end
            else
            begin
                token_open_next  = 1'b1;
                held_tab_next    = (text_byte == CH_TAB);
                kept_length_next = len_after_tab;
                if (keep_tab)
                begin
                    all_digits_next     = 1'b0;
                    digits_or_dots_next = 1'b0;
                    if (kept_length_reg == '0)
                        first_kept_next = CH_TAB;
                end
                if (keep_byte)
                begin
                    if ((text_byte >= CH_ZERO) && (text_byte <= CH_NINE))
                    begin
                        // digit: flags unchanged
                    end
                    else if (text_byte == CH_DOT)
                    begin
                        all_digits_next = 1'b0;
                        saw_dot_next    = 1'b1;
                    end
                    else
                    begin
                        all_digits_next     = 1'b0;
                        digits_or_dots_next = 1'b0;
                    end
                    if (len_after_tab == '0)
                        first_kept_next = text_byte;
                    if (len_after_tab != LEN_W'(MAX_TOKEN_LEN))
                        kept_length_next = len_after_tab + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_open_reg     <= 1'b0;
            kept_length_reg    <= '0;
            first_kept_reg     <= 8'd0;
            all_digits_reg     <= 1'b1;
            digits_or_dots_reg <= 1'b1;
            saw_dot_reg        <= 1'b0;
            held_tab_reg       <= 1'b0;
        end
        else
        begin
            token_open_reg     <= token_open_next;
            kept_length_reg    <= kept_length_next;
            first_kept_reg     <= first_kept_next;
            all_digits_reg     <= all_digits_next;
            digits_or_dots_reg <= digits_or_dots_next;
            saw_dot_reg        <= saw_dot_next;
            held_tab_reg       <= held_tab_next;
        end
    end

    // Head characters carry no reset; only written entries are ever compared.
    always_ff @(posedge clk)
    begin
        if (accept && !closes)
        begin
            if (head_wr_a)
                head_chars_reg[kept_length_reg[HEAD_W-1:0]] <= CH_TAB;
            if (head_wr_b)
                head_chars_reg[len_after_tab[HEAD_W-1:0]] <= text_byte;
        end
    end

endmodule

// ----- design/ctc_result_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_result_queue
// Result register holding one byte's bundle and handing it out in order.
// ----------------------------------------------------------------------------
module ctc_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ctc_pkg::bundle_t bundle,
    output logic             take_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output ctc_pkg::result_t out_res
);
    import ctc_pkg::*;

    logic [1:0]    count_reg, count_next;
    result_t [2:0] slot_reg, slot_next;
    logic          out_fire;

    assign out_valid = (count_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign take_ok   = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);
    assign out_res   = slot_reg[0];

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (out_fire)
        begin
            // advance the remaining results towards the head
            slot_next  = {result_t'('0), slot_reg[2], slot_reg[1]};
            count_next = count_reg - 2'd1;
        end
        if (accept && (bundle.count != 2'd0))
        begin
            slot_next  = bundle.res;
            count_next = bundle.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule
